>>> src/wksc_pkg.sv
// ----------------------------------------------------------------------------
// wksc_pkg
// Shared codes and constants for the word keyed shift cipher unit.
// ----------------------------------------------------------------------------
package wksc_pkg;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_ENC  = 2'd1,
		FUNC_DEC  = 2'd2
	} func_t;

	localparam int unsigned BYTE_W = 8;

	// key text word separators
	localparam logic [BYTE_W-1:0] SEP_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] SEP_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] SEP_NUL     = 8'h00;

	function automatic logic is_separator(input logic [BYTE_W-1:0] b);
		return (b == SEP_SPACE) || (b == SEP_NEWLINE) || (b == SEP_NUL);
	endfunction

endpackage

>>> src/word_keyed_shift_cipher_unit.sv
// ----------------------------------------------------------------------------
// word_keyed_shift_cipher_unit
// Byte cipher keyed by per-word byte sums of a streamed key text.
// ----------------------------------------------------------------------------
// Key bytes (func load) build a table of shifts, one per finished non-empty
// word; space, newline or zero ends a word and a trailing word without a
// separator is not stored. Encrypt adds and decrypt subtracts the shift of the
// current word mod 256, stepping through the stored words once per byte. With
// no word stored the byte passes unchanged and no_key is set. One transaction
// is accepted every cycle while in_ready is high; out_valid rises after its
// input is accepted, through two register stages: the registered read of the
// shift table, then the result register. in_ready drops only while both stages
// hold a result and out_ready is low. Key loads and unused func codes give no
// result. Table depth is MAX_WORDS; extra words are dropped.
module word_keyed_shift_cipher_unit
	import wksc_pkg::*;
#(
	parameter int unsigned MAX_WORDS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              starts_run,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              no_key
);

	localparam int unsigned CNT_W = $clog2(MAX_WORDS + 1);
	localparam int unsigned IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	// state
	logic [CNT_W-1:0]  word_count_q;
	logic [BYTE_W-1:0] word_sum_q;
	logic              in_word_q;
	logic [IDX_W-1:0]  position_q;

	logic [BYTE_W-1:0] shift_mem [MAX_WORDS];

	// read stage
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic [BYTE_W-1:0] shift_s1;
	logic              enc_s1;
	logic              no_key_s1;

	logic in_fire;
	logic adv_s1;
	logic is_load;
	logic is_cipher;
	logic is_enc;

	logic [CNT_W-1:0]  wc_eff;
	logic [BYTE_W-1:0] sum_eff;
	logic              in_word_eff;
	logic              wc_full;
	logic              sep;
	logic              store_word;

	logic [IDX_W-1:0] pos_eff;
	logic [IDX_W-1:0] rd_idx;
	logic [CNT_W-1:0] nxt_idx;
	logic [IDX_W-1:0] pos_next;
	logic             key_empty;

	assign adv_s1   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || !out_valid || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		is_load   = 1'b0;
		is_cipher = 1'b0;
		is_enc    = 1'b0;
		unique case (func)
			FUNC_LOAD: begin
				is_load = 1'b1;
			end
			FUNC_ENC: begin
				is_cipher = 1'b1;
				is_enc    = 1'b1;
			end
			FUNC_DEC: begin
				is_cipher = 1'b1;
			end
			default: begin
				is_load   = 1'b0;
			end
		endcase
	end

	// key word builder, a restart wipes the table before this byte
	always_comb begin
		wc_eff      = starts_run ? '0 : word_count_q;
		sum_eff     = starts_run ? '0 : word_sum_q;
		in_word_eff = starts_run ? 1'b0 : in_word_q;
		wc_full     = (wc_eff == CNT_W'(MAX_WORDS));
		sep         = is_separator(data_byte);
		store_word  = sep && in_word_eff && !wc_full;
	end

	// position handling for cipher bytes
	always_comb begin
		pos_eff   = starts_run ? '0 : position_q;
		key_empty = (word_count_q == '0);
		// key reload may leave the position past the stored words
		if (CNT_W'(pos_eff) >= word_count_q) begin
			rd_idx = '0;
		end else begin
			rd_idx = pos_eff;
		end
		nxt_idx = CNT_W'(rd_idx) + CNT_W'(1);
		if (key_empty) begin
			pos_next = pos_eff;
		end else if (nxt_idx >= word_count_q) begin
			pos_next = '0;
		end else begin
			pos_next = nxt_idx[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
			word_sum_q   <= '0;
			in_word_q    <= 1'b0;
			position_q   <= '0;
		end else if (in_fire) begin
			if (is_load) begin
				if (sep) begin
					word_count_q <= store_word ? wc_eff + CNT_W'(1) : wc_eff;
					word_sum_q   <= '0;
					in_word_q    <= 1'b0;
				end else begin
					word_count_q <= wc_eff;
					word_sum_q   <= sum_eff + data_byte;
					in_word_q    <= 1'b1;
				end
			end else if (is_cipher) begin
				position_q <= pos_next;
			end
		end
	end

	// shift table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (in_fire && is_load && store_word) begin
			shift_mem[wc_eff[IDX_W-1:0]] <= sum_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_cipher) begin
			shift_s1  <= shift_mem[rd_idx];
			data_s1   <= data_byte;
			enc_s1    <= is_enc;
			no_key_s1 <= key_empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire && is_cipher) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			no_key <= no_key_s1;
			if (no_key_s1) begin
				out_byte <= data_s1;
			end else if (enc_s1) begin
				out_byte <= data_s1 + shift_s1;
			end else begin
				out_byte <= data_s1 - shift_s1;
			end
		end
	end

	// assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		word_count_q <= CNT_W'(MAX_WORDS))
		else $error("word count above table depth");

	a_idle_sum: assert property (@(posedge clk) disable iff (!arst_n)
		!in_word_q |-> (word_sum_q == '0))
		else $error("word sum left over outside a word");

	a_no_key_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_cipher && key_empty) |=> (valid_s1 && no_key_s1))
		else $error("cipher transaction without key not flagged");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are held");

endmodule

>>> tb/sv/word_keyed_shift_cipher_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// word_keyed_shift_cipher_unit_tb
// Self-checking testbench for the word keyed shift cipher unit.
// ----------------------------------------------------------------------------
// Streams key text and message bytes into the unit under random handshake
// gaps on both sides. A scoreboard predicts every cipher byte from its own
// copy of the shift table and word position and compares each output
// transaction in order.
// ----------------------------------------------------------------------------
module word_keyed_shift_cipher_unit_tb
	import wksc_pkg::*;
;

	localparam int unsigned TABLE_DEPTH    = 16;
	localparam int unsigned RANDOM_ITEMS   = 950;
	localparam int unsigned HOLD_CYCLES    = 64;
	localparam int unsigned BURST_LEN      = 40;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned MAX_REPORTS    = 10;
	// func code the unit ignores
	localparam logic [1:0]  FUNC_UNUSED    = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] cipher;
		logic              keyless;
	} cipher_out_t;

	class cipher_scoreboard;
		logic [BYTE_W-1:0] shift_tab [TABLE_DEPTH];
		logic [4:0]        n_words     = '0;
		logic [BYTE_W-1:0] partial_sum = '0;
		bit                building    = 1'b0;
		logic [3:0]        word_pos    = '0;
		cipher_out_t       cipher_q[$];
		int unsigned       mismatches  = 0;

		function int unsigned pending();
			return cipher_q.size();
		endfunction

		function void note_input(logic [1:0] f, logic [BYTE_W-1:0] b, logic start);
			int unsigned       idx;
			logic [BYTE_W-1:0] res;
			case (f)
				FUNC_LOAD: begin
					if (start) begin
						n_words     = '0;
						partial_sum = '0;
						building    = 1'b0;
					end
					if (b == SEP_SPACE || b == SEP_NEWLINE || b == SEP_NUL) begin
						// an empty word stores nothing, a full table drops the word
						if (building) begin
							if (n_words < TABLE_DEPTH) begin
								shift_tab[n_words] = partial_sum;
								n_words++;
							end
							partial_sum = '0;
							building    = 1'b0;
						end
					end else begin
						partial_sum = partial_sum + b;
						building    = 1'b1;
					end
				end
				FUNC_ENC, FUNC_DEC: begin
					if (start)
						word_pos = '0;
					if (n_words == 0) begin
						cipher_q.push_back('{b, 1'b1});
					end else begin
						// position may lie past the table after a key reload
						idx = word_pos;
						if (idx >= n_words)
							idx = 0;
						if (f == FUNC_ENC)
							res = b + shift_tab[idx];
						else
							res = b - shift_tab[idx];
						idx++;
						if (idx >= n_words)
							idx = 0;
						word_pos = idx[3:0];
						cipher_q.push_back('{res, 1'b0});
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(logic [BYTE_W-1:0] got_byte, logic got_flag);
			cipher_out_t exp_out;
			if (cipher_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected transaction: out_byte %02h no_key %0b",
						got_byte, got_flag);
				return;
			end
			exp_out = cipher_q.pop_front();
			if (got_byte !== exp_out.cipher || got_flag !== exp_out.keyless) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: out_byte exp %02h got %02h, no_key exp %0b got %0b",
						exp_out.cipher, got_byte, exp_out.keyless, got_flag);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        func;
	logic [BYTE_W-1:0] data_byte;
	logic              starts_run;
	logic              out_valid;
	logic              out_ready;
	logic [BYTE_W-1:0] out_byte;
	logic              no_key;

	cipher_scoreboard sb;
	int unsigned      sent_items  = 0;
	int unsigned      quiet_cycles = 0;
	bit               idle_on     = 1'b1;
	bit               hold_req    = 1'b0;

	word_keyed_shift_cipher_unit #(
		.MAX_WORDS(TABLE_DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.data_byte (data_byte),
		.starts_run(starts_run),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.no_key    (no_key)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [1:0] f, input logic [BYTE_W-1:0] b,
		input logic start);
		while (idle_on && $urandom_range(99) < 14) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		func       = f;
		data_byte  = b;
		starts_run = start;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (f != FUNC_UNUSED)
			sent_items++;
	endtask

	task automatic wait_for_drain();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic send_key_text(input bit fresh, input int unsigned n_words,
		input bit trailing);
		bit          first;
		int unsigned len;
		logic [BYTE_W-1:0] sep;
		first = fresh;
		for (int w = 0; w < n_words + (trailing ? 1 : 0); w++) begin
			len = $urandom_range(4, 1);
			for (int k = 0; k < len; k++) begin
				send_item(FUNC_LOAD, BYTE_W'($urandom_range(255)), first);
				first = 1'b0;
			end
			if (w < n_words) begin
				repeat (($urandom_range(3) == 0) ? 2 : 1) begin
					case ($urandom_range(2))
						0: sep = SEP_SPACE;
						1: sep = SEP_NEWLINE;
						default: sep = SEP_NUL;
					endcase
					send_item(FUNC_LOAD, sep, 1'b0);
				end
			end
		end
		// empty restart clears the table entirely
		if (first)
			send_item(FUNC_LOAD, SEP_SPACE, 1'b1);
	endtask

	task automatic send_message(input int unsigned len);
		logic start;
		for (int i = 0; i < len; i++) begin
			start = (i == 0 && $urandom_range(9) != 0) || $urandom_range(31) == 0;
			send_item($urandom_range(1) ? FUNC_ENC : FUNC_DEC,
				BYTE_W'($urandom_range(255)), start);
		end
	endtask

	// receiver side, with one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready = !(idle_on && $urandom_range(99) < 14);
		end
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_input(func, data_byte, starts_run);
		if (out_valid && out_ready)
			sb.check_result(out_byte, no_key);
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned target;
		int unsigned pick;
		bit          burst_done;
		bit          drain_done;
		sb         = new();
		burst_done = 1'b0;
		drain_done = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		func       = FUNC_LOAD;
		data_byte  = '0;
		starts_run = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no key stored yet: bytes pass through flagged
		send_item(FUNC_ENC, 8'h41, 1'b1);
		send_item(FUNC_DEC, 8'hFF, 1'b0);
		send_item(FUNC_UNUSED, 8'hA5, 1'b1);
		// key with repeated separators, all three separator kinds and an unfinished word
		send_item(FUNC_LOAD, 8'h61, 1'b1);
		send_item(FUNC_LOAD, 8'hFF, 1'b0);
		send_item(FUNC_LOAD, SEP_SPACE, 1'b0);
		send_item(FUNC_LOAD, SEP_SPACE, 1'b0);
		send_item(FUNC_LOAD, 8'h01, 1'b0);
		send_item(FUNC_LOAD, SEP_NEWLINE, 1'b0);
		send_item(FUNC_LOAD, 8'h80, 1'b0);
		send_item(FUNC_LOAD, SEP_NUL, 1'b0);
		send_item(FUNC_LOAD, 8'h7F, 1'b0);
		send_item(FUNC_ENC, 8'hFF, 1'b1);
		send_item(FUNC_ENC, 8'h00, 1'b0);
		send_item(FUNC_DEC, 8'h00, 1'b0);
		send_item(FUNC_DEC, 8'hFF, 1'b0);
		send_item(FUNC_ENC, 8'h55, 1'b0);
		// shorter key mid-message: position wraps before use
		send_item(FUNC_LOAD, 8'h05, 1'b1);
		send_item(FUNC_LOAD, SEP_SPACE, 1'b0);
		send_item(FUNC_ENC, 8'hC3, 1'b0);

		target = sent_items + RANDOM_ITEMS;
		while (sent_items < target) begin
			if (!burst_done && sent_items >= 300) begin
				burst_done = 1'b1;
				hold_req   = 1'b1;
				send_message(BURST_LEN);
			end
			if (!drain_done && sent_items >= 650) begin
				drain_done = 1'b1;
				wait_for_drain();
			end
			// long stretch without gaps on either side
			idle_on = !(sent_items >= 420 && sent_items < 620);
			pick = $urandom_range(99);
			if (pick < 22) begin
				send_key_text($urandom_range(4) != 0,
					($urandom_range(7) == 0) ? $urandom_range(20, 17) : $urandom_range(6, 0),
					$urandom_range(3) == 0);
			end else if (pick < 85) begin
				send_message($urandom_range(40, 1));
			end else if (pick < 95) begin
				repeat ($urandom_range(5, 1))
					send_item(2'($urandom_range(3)), BYTE_W'($urandom_range(255)),
						1'($urandom_range(1)));
			end else begin
				send_item(FUNC_UNUSED, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
			end
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
src/wksc_pkg.sv
src/word_keyed_shift_cipher_unit.sv
tb/sv/word_keyed_shift_cipher_unit_tb.sv
